### hw/rtl/bsr_pkg.sv
// Shared types and constants for the bisection square root block.
// Depends on nothing; every other file in hw/rtl imports it.
package bsr_pkg;

    localparam int DATA_W                 = 32;
    localparam int FRAC_W                 = 16;
    localparam int SQ_W                   = 2 * DATA_W;
    localparam int DEFAULT_MAX_ITERATIONS = 40;

    localparam logic [DATA_W-1:0] ONE_Q16 = 32'h0001_0000;

    typedef enum logic [1:0] {
        STATUS_CONVERGED = 2'd0,
        STATUS_EXACT     = 2'd1,
        STATUS_CAP       = 2'd2
    } bsr_status_t;

    typedef struct packed {
        logic [DATA_W-1:0] root;
        logic [DATA_W-1:0] low_bound;
        logic [DATA_W-1:0] high_bound;
        bsr_status_t       status;
    } bsr_result_t;

endpackage

### hw/rtl/bsr_if.sv
// Valid/ready channel interfaces for operand and result words.
// Depends on bsr_pkg for field widths.
interface bsr_in_if
    import bsr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] radicand;
    logic [DATA_W-1:0] tolerance;

    modport source (output valid, output radicand, output tolerance, input ready);
    modport sink   (input valid, input radicand, input tolerance, output ready);
endinterface

interface bsr_out_if
    import bsr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] root;
    logic [DATA_W-1:0] low_bound;
    logic [DATA_W-1:0] high_bound;
    logic [1:0]        status;

    modport source (output valid, output root, output low_bound, output high_bound,
                    output status, input ready);
    modport sink   (input valid, input root, input low_bound, input high_bound,
                    input status, output ready);
endinterface

### hw/rtl/bsr_squarer.sv
// Shared registered 32x32 squarer, Q16.16 in, Q32.32 out.
// Depends on bsr_pkg.
module bsr_squarer
    import bsr_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [DATA_W-1:0] x,
    output logic [SQ_W-1:0]   sq
);

    logic [SQ_W-1:0] sq_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg <= SQ_W'(x) * SQ_W'(x);
        end
    end

    assign sq = sq_reg;

endmodule

### hw/rtl/bsr_seq.sv
// Bisection sequencer: bounds, midpoint, tolerance compare and iteration count.
// Depends on bsr_pkg and drives one shared bsr_squarer.
module bsr_seq
    import bsr_pkg::*;
#(
    parameter int MAX_ITERATIONS = DEFAULT_MAX_ITERATIONS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] radicand,
    input  logic [DATA_W-1:0] tolerance,
    output logic              res_valid,
    input  logic              res_ready,
    output bsr_result_t       res
);

    localparam int CNT_W = $clog2(MAX_ITERATIONS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SQUARE,
        S_CHECK,
        S_DONE
    } state_t;

    state_t            state_reg;
    logic              first_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [DATA_W-1:0] radicand_reg;
    logic [DATA_W-1:0] tolerance_reg;
    logic [DATA_W-1:0] lo_reg;
    logic [DATA_W-1:0] hi_reg;
    logic [DATA_W-1:0] x_reg;
    bsr_status_t       status_reg;

    logic [SQ_W-1:0]   sq;
    logic [SQ_W-1:0]   target;
    logic [SQ_W-1:0]   limit;
    logic [SQ_W-1:0]   gap;
    logic              below;
    logic [DATA_W-1:0] lo_upd;
    logic [DATA_W-1:0] hi_upd;
    logic [DATA_W:0]   mid_sum;
    logic [DATA_W-1:0] hi_init;

    bsr_squarer u_squarer (
        .clk (clk),
        .en  (state_reg == S_SQUARE),
        .x   (x_reg),
        .sq  (sq)
    );

    always_comb
    begin
        target  = {{(SQ_W-DATA_W-FRAC_W){1'b0}}, radicand_reg, {FRAC_W{1'b0}}};
        limit   = {{(SQ_W-DATA_W-FRAC_W){1'b0}}, tolerance_reg, {FRAC_W{1'b0}}};
        below   = sq < target;
        gap     = below ? (target - sq) : (sq - target);
        lo_upd  = below ? x_reg : lo_reg;
        hi_upd  = below ? hi_reg : x_reg;
        mid_sum = {1'b0, lo_upd} + {1'b0, hi_upd};
        hi_init = (radicand > ONE_Q16) ? radicand : ONE_Q16;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            first_reg     <= 1'b0;
            count_reg     <= '0;
            radicand_reg  <= '0;
            tolerance_reg <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            x_reg         <= '0;
            status_reg    <= STATUS_CONVERGED;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        radicand_reg  <= radicand;
                        tolerance_reg <= tolerance;
                        lo_reg        <= '0;
                        hi_reg        <= hi_init;
                        first_reg     <= 1'b1;
                        count_reg     <= '0;
                        if (radicand == '0)
                        begin
                            x_reg      <= '0;
                            status_reg <= STATUS_EXACT;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            x_reg     <= hi_init;
                            state_reg <= S_SQUARE;
                        end
                    end
                end
                S_SQUARE:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (first_reg)
                    begin
                        first_reg <= 1'b0;
                        if (sq == target)
                        begin
                            status_reg <= STATUS_EXACT;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            x_reg     <= hi_reg >> 1;
                            state_reg <= S_SQUARE;
                        end
                    end
                    else if (gap <= limit)
                    begin
                        status_reg <= STATUS_CONVERGED;
                        state_reg  <= S_DONE;
                    end
                    else if (count_reg >= CNT_W'(MAX_ITERATIONS))
                    begin
                        status_reg <= STATUS_CAP;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        lo_reg    <= lo_upd;
                        hi_reg    <= hi_upd;
                        x_reg     <= mid_sum[DATA_W:1];
                        count_reg <= count_reg + CNT_W'(1);
                        state_reg <= S_SQUARE;
                    end
                end
                S_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign res_valid      = (state_reg == S_DONE);
    assign res.root       = x_reg;
    assign res.low_bound  = lo_reg;
    assign res.high_bound = hi_reg;
    assign res.status     = status_reg;

endmodule

### hw/rtl/bisection_square_root.sv
// Bisection square root, unsigned Q16.16, with one shared registered squarer.
// A zero radicand skips the squarer; a high endpoint that squares exactly ends at the first check;
// otherwise the search stops at tolerance or after MAX_ITERATIONS midpoint updates.
// Each bisection step squares into a register, then compares and updates.
// One word in flight: a new operand word is taken only once the sequencer is back in idle.
// Reset (rst_n, async) returns the sequencer to idle and empties the output register.
module bisection_square_root
    import bsr_pkg::*;
#(
    parameter int MAX_ITERATIONS = DEFAULT_MAX_ITERATIONS
)
(
    input logic     clk,
    input logic     rst_n,
    bsr_in_if.sink  operand,
    bsr_out_if.source result
);

    logic        res_valid;
    logic        res_ready;
    bsr_result_t res;
    logic        out_valid_reg;
    bsr_result_t out_reg;

    bsr_seq #(
        .MAX_ITERATIONS (MAX_ITERATIONS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (operand.valid),
        .in_ready  (operand.ready),
        .radicand  (operand.radicand),
        .tolerance (operand.tolerance),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.root       = out_reg.root;
    assign result.low_bound  = out_reg.low_bound;
    assign result.high_bound = out_reg.high_bound;
    assign result.status     = out_reg.status;

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.status == STATUS_CONVERGED || out_reg.status == STATUS_EXACT
                           || out_reg.status == STATUS_CAP))
        else $error("result status out of range");

    a_root_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status != STATUS_EXACT) |->
            (out_reg.low_bound <= out_reg.root && out_reg.root <= out_reg.high_bound))
        else $error("root outside final interval");

    a_exact_endpoint: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status == STATUS_EXACT) |->
            (out_reg.root == out_reg.high_bound || out_reg.root == out_reg.low_bound))
        else $error("exact result is not an endpoint");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !operand.ready)
        else $error("operand accepted while result pending");

endmodule

### dv/tb_top.sv
// Testbench for bisection_square_root: random and corner operand words, each result checked
// field by field against an in-bench bisection predictor. Depends on bsr_pkg and bsr_if.
module tb_top;
    import bsr_pkg::*;

    localparam int MAX_STEPS     = DEFAULT_MAX_ITERATIONS;
    localparam int WORST_LATENCY = 2 * MAX_STEPS + 6;
    localparam int RANDOM_WORDS  = 1030;
    localparam int CALM_FIRST    = 150;
    localparam int CALM_LAST     = 400;
    localparam int HOLD_AT       = 500;
    localparam int HOLD_CYCLES   = 400;
    localparam int PAUSE_AT      = 750;
    localparam int STALL_LIMIT   = 8 * (HOLD_CYCLES + WORST_LATENCY);
    localparam int PRINT_LIMIT   = 100;

    typedef struct packed {
        logic [DATA_W-1:0] radicand;
        logic [DATA_W-1:0] tolerance;
    } operand_word_t;

    logic clk;
    logic rst_n;

    bsr_in_if  operand ();
    bsr_out_if result ();

    bisection_square_root #(.MAX_ITERATIONS(MAX_STEPS)) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand),
        .result  (result)
    );

    operand_word_t pending_words[$];
    bsr_result_t   expected_roots[$];
    int            words_taken;
    int            words_accepted;
    int            results_checked;
    int            mismatches = 0;
    int            hold_left;
    int            idle_cycles;

    always #2 clk = ~clk;

    function automatic bsr_result_t compute_root(logic [DATA_W-1:0] radicand,
                                                 logic [DATA_W-1:0] tolerance);
        logic [SQ_W-1:0]   target;
        logic [SQ_W-1:0]   margin;
        logic [SQ_W-1:0]   square;
        logic [SQ_W-1:0]   gap;
        logic [DATA_W:0]   span;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] mid;
        int                steps;
        bsr_result_t       r;
        target = {{(SQ_W-DATA_W-FRAC_W){1'b0}}, radicand, {FRAC_W{1'b0}}};
        margin = {{(SQ_W-DATA_W-FRAC_W){1'b0}}, tolerance, {FRAC_W{1'b0}}};
        lo = '0;
        hi = (radicand > ONE_Q16) ? radicand : ONE_Q16;
        r.root       = '0;
        r.low_bound  = '0;
        r.high_bound = hi;
        r.status     = STATUS_EXACT;
        if (radicand == '0)
            return r;
        square = {{DATA_W{1'b0}}, hi} * {{DATA_W{1'b0}}, hi};
        if (square == target)
        begin
            r.root = hi;
            return r;
        end
        span  = {1'b0, lo} + {1'b0, hi};
        mid   = span[DATA_W:1];
        steps = 0;
        r.status = STATUS_CONVERGED;
        forever
        begin
            square = {{DATA_W{1'b0}}, mid} * {{DATA_W{1'b0}}, mid};
            gap    = (square >= target) ? square - target : target - square;
            if (gap <= margin)
                break;
            if (steps >= MAX_STEPS)
            begin
                r.status = STATUS_CAP;
                break;
            end
            if (square < target)
                lo = mid;
            else
                hi = mid;
            span = {1'b0, lo} + {1'b0, hi};
            mid  = span[DATA_W:1];
            steps++;
        end
        r.root       = mid;
        r.low_bound  = lo;
        r.high_bound = hi;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch: %s on result %0d: got %h, expected %h",
                     what, results_checked, got, want);
        mismatches++;
    endtask

    task automatic queue_word(logic [DATA_W-1:0] radicand, logic [DATA_W-1:0] tolerance);
        operand_word_t w;
        w.radicand  = radicand;
        w.tolerance = tolerance;
        pending_words.push_back(w);
    endtask

    function automatic logic [DATA_W-1:0] pick_radicand();
        logic [DATA_W-1:0] k;
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return $urandom_range(0, 32'h0000_FFFF);
            2:
            begin
                k = $urandom_range(0, 16'hFFFF);
                return k * k;
            end
            3:       return $urandom >> $urandom_range(0, 31);
            4:       return $urandom_range(0, 3) << ($urandom_range(0, 1) * 16);
            default: return ~($urandom >> $urandom_range(0, 31));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_tolerance();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return $urandom_range(0, 255);
            2:       return $urandom;
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        operand_word_t w;
        bit            take;
        int            words_in;
        if (!rst_n)
        begin
            operand.valid     <= 1'b0;
            operand.radicand  <= '0;
            operand.tolerance <= '0;
            words_taken       = 0;
            words_accepted    <= 0;
        end
        else
        begin
            words_in = words_accepted;
            if (operand.valid && operand.ready)
            begin
                expected_roots.push_back(compute_root(operand.radicand, operand.tolerance));
                words_accepted <= words_accepted + 1;
                words_in++;
            end
            if (!operand.valid || operand.ready)
            begin
                take = pending_words.size() != 0;
                // drain everything once before the next word
                if (words_taken == PAUSE_AT && words_in != results_checked)
                    take = 0;
                if ((words_taken < CALM_FIRST || words_taken > CALM_LAST)
                    && $urandom_range(0, 99) < 30)
                    take = 0;
                if (take)
                begin
                    w = pending_words.pop_front();
                    operand.radicand  <= w.radicand;
                    operand.tolerance <= w.tolerance;
                    operand.valid     <= 1'b1;
                    words_taken++;
                end
                else
                    operand.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        bsr_result_t want;
        if (!rst_n)
        begin
            result.ready    <= 1'b0;
            results_checked <= 0;
            hold_left       = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                results_checked <= results_checked + 1;
                if (expected_roots.size() == 0)
                    report_mismatch("unexpected word, root", result.root, '0);
                else
                begin
                    want = expected_roots.pop_front();
                    if (result.root !== want.root)
                        report_mismatch("root", result.root, want.root);
                    if (result.low_bound !== want.low_bound)
                        report_mismatch("low_bound", result.low_bound, want.low_bound);
                    if (result.high_bound !== want.high_bound)
                        report_mismatch("high_bound", result.high_bound, want.high_bound);
                    if (result.status !== want.status)
                        report_mismatch("status", DATA_W'(result.status),
                                        DATA_W'(want.status));
                end
                if (results_checked + 1 == HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result.ready <= 1'b0;
            end
            else if (results_checked >= CALM_FIRST && results_checked <= CALM_LAST)
                result.ready <= 1'b1;
            else
                result.ready <= ($urandom_range(0, 99) >= 30);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles = 0;
        else
        begin
            if ((operand.valid && operand.ready) || (result.valid && result.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        clk   = 1'b0;
        rst_n = 1'b0;

        queue_word(32'h0000_0000, 32'h0000_0000);
        queue_word(32'h0000_0000, 32'hFFFF_FFFF);
        queue_word(ONE_Q16,       32'h0000_0000);
        queue_word(ONE_Q16,       32'hFFFF_FFFF);
        queue_word(32'h0004_0000, 32'h0000_0000);
        queue_word(32'h0009_0000, 32'h0000_0000);
        queue_word(32'h0002_0000, 32'h0000_0000);
        queue_word(32'h0002_0000, 32'h0000_0100);
        queue_word(32'h0000_4000, 32'h0000_0000);
        queue_word(32'h0000_0001, 32'h0000_0000);
        queue_word(32'h0000_0001, 32'hFFFF_FFFF);
        queue_word(32'h0000_FFFF, 32'h0000_0000);
        queue_word(32'h0001_0001, 32'h0000_0000);
        queue_word(32'hFFFF_FFFF, 32'h0000_0000);
        queue_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_word(32'hFFFF_0000, 32'h0001_0000);
        queue_word(32'hFFFE_0001, 32'h0000_0000);
        queue_word(32'h8000_0000, 32'h0000_0001);
        queue_word(32'h7FFF_FFFF, 32'h8000_0000);
        queue_word(32'h0000_0100, 32'h0000_FFFF);
        repeat (RANDOM_WORDS)
            queue_word(pick_radicand(), pick_tolerance());

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        do
            @(posedge clk);
        while (pending_words.size() != 0 || operand.valid
               || words_accepted != results_checked);
        repeat (WORST_LATENCY + 10) @(posedge clk);

        if (expected_roots.size() != 0)
            report_mismatch("missing result words", '0, DATA_W'(expected_roots.size()));

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
